[sv/sqw_pkg.sv]
`default_nettype none

package sqw_pkg;

  // event codes carried in the func field
  typedef enum logic [2:0] {
    FUNC_REG0    = 3'd0,
    FUNC_REG1    = 3'd1,
    FUNC_REG2    = 3'd2,
    FUNC_REG3    = 3'd3,
    FUNC_ENABLE  = 3'd4,
    FUNC_TIMER   = 3'd5,
    FUNC_QUARTER = 3'd6,
    FUNC_HALF    = 3'd7
  } func_t;

  localparam logic [10:0] PERIOD_MAX   = 11'h7FF;
  localparam logic [10:0] PERIOD_MIN   = 11'd8;
  localparam logic [3:0]  ENV_TOP      = 4'd15;
  localparam logic [11:0] TIMER_RESET  = 12'd1;

  typedef struct packed {
    logic [1:0]  duty_mode;
    logic        halt_loop;
    logic        constant_volume;
    logic [3:0]  volume_value;
    logic        sweep_on;
    logic [2:0]  sweep_divider_period;
    logic        sweep_down;
    logic [2:0]  sweep_amount;
    logic        sweep_reload;
    logic [2:0]  sweep_divider;
    logic [10:0] period_value;
    logic [11:0] timer_count;
    logic [2:0]  duty_position;
    logic [7:0]  length_count;
    logic        channel_enabled;
    logic        envelope_start;
    logic [3:0]  envelope_level;
    logic [3:0]  envelope_divider;
  } chan_state_t;

  // one output bit of the 8-step duty sequence
  function automatic logic duty_bit(input logic [1:0] mode, input logic [2:0] pos);
    logic [7:0] seq;
    unique case (mode)
      2'd0: seq = 8'b0000_0010;
      2'd1: seq = 8'b0000_0110;
      2'd2: seq = 8'b0001_1110;
      2'd3: seq = 8'b1111_1001;
      default: seq = 8'b0000_0000;
    endcase
    return seq[pos];
  endfunction

  // length counter load values
  function automatic logic [7:0] length_load(input logic [4:0] idx);
    logic [7:0] v;
    unique case (idx)
      5'd0:  v = 8'd10;   5'd1:  v = 8'd254;  5'd2:  v = 8'd20;   5'd3:  v = 8'd2;
      5'd4:  v = 8'd40;   5'd5:  v = 8'd4;    5'd6:  v = 8'd80;   5'd7:  v = 8'd6;
      5'd8:  v = 8'd160;  5'd9:  v = 8'd8;    5'd10: v = 8'd60;   5'd11: v = 8'd10;
      5'd12: v = 8'd14;   5'd13: v = 8'd12;   5'd14: v = 8'd26;   5'd15: v = 8'd14;
      5'd16: v = 8'd12;   5'd17: v = 8'd16;   5'd18: v = 8'd24;   5'd19: v = 8'd18;
      5'd20: v = 8'd48;   5'd21: v = 8'd20;   5'd22: v = 8'd96;   5'd23: v = 8'd22;
      5'd24: v = 8'd192;  5'd25: v = 8'd24;   5'd26: v = 8'd72;   5'd27: v = 8'd26;
      5'd28: v = 8'd16;   5'd29: v = 8'd28;   5'd30: v = 8'd32;   5'd31: v = 8'd30;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[sv/sqw_if.sv]
`default_nettype none

// event word: func and data
interface sqw_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] data;

  modport source (output valid, output func, output data, input ready);
  modport sink   (input valid, input func, input data, output ready);
endinterface

// result word: level and length status
interface sqw_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] level;
  logic       length_active;

  modport source (output valid, output level, output length_active, input ready);
  modport sink   (input valid, input level, input length_active, output ready);
endinterface

`default_nettype wire

[sv/sqw_sweep.sv]
`default_nettype none

// sweep target adder with overflow and range flags
module sqw_sweep (
  input  wire logic [10:0] period,
  input  wire logic [2:0]  amount,
  input  wire logic        down,
  input  wire logic        ones_comp,
  output logic      [10:0] target,
  output logic             overflow,
  output logic             in_range
);

  logic [10:0] shifted;
  logic [12:0] sum;

  always_comb begin
    shifted = period >> amount;
    if (down) begin
      sum = {2'b00, period} - {2'b00, shifted} - {12'd0, ones_comp};
    end else begin
      sum = {2'b00, period} + {2'b00, shifted};
    end
    // bit 12 marks a negative result, bit 11 a result beyond the period range
    overflow = !sum[12] && sum[11];
    in_range = !sum[12] && !sum[11];
    target   = sum[10:0];
  end

endmodule

`default_nettype wire

[sv/sqw_core.sv]
`default_nettype none

// channel state and per-event update, level worked out from the new state
module sqw_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [2:0] func,
  input  wire logic [7:0] data,
  input  wire logic       first_channel,
  output logic      [3:0] level_next,
  output logic            length_active_next
);

  sqw_pkg::chan_state_t st, st_next, st_reset;

  logic [10:0] tgt_cur, tgt_new;
  logic        ovf_cur, ovf_new;
  logic        rng_cur, rng_new;
  logic [11:0] timer_dec;

  sqw_sweep u_sweep_cur (
    .period    (st.period_value),
    .amount    (st.sweep_amount),
    .down      (st.sweep_down),
    .ones_comp (first_channel),
    .target    (tgt_cur),
    .overflow  (ovf_cur),
    .in_range  (rng_cur)
  );

  sqw_sweep u_sweep_new (
    .period    (st_next.period_value),
    .amount    (st_next.sweep_amount),
    .down      (st_next.sweep_down),
    .ones_comp (first_channel),
    .target    (tgt_new),
    .overflow  (ovf_new),
    .in_range  (rng_new)
  );

  // reset image: everything clear except the timer, which starts at one
  always_comb begin
    st_reset             = '0;
    st_reset.timer_count = sqw_pkg::TIMER_RESET;
  end

  always_comb begin
    st_next   = st;
    timer_dec = st.timer_count - 12'd1;
    unique case (sqw_pkg::func_t'(func))
      sqw_pkg::FUNC_REG0: begin
        st_next.duty_mode       = data[7:6];
        st_next.halt_loop       = data[5];
        st_next.constant_volume = data[4];
        st_next.volume_value    = data[3:0];
      end
      sqw_pkg::FUNC_REG1: begin
        st_next.sweep_on             = data[7];
        st_next.sweep_divider_period = data[6:4];
        st_next.sweep_down           = data[3];
        st_next.sweep_amount         = data[2:0];
        st_next.sweep_reload         = 1'b1;
      end
      sqw_pkg::FUNC_REG2: begin
        st_next.period_value = {st.period_value[10:8], data};
      end
      sqw_pkg::FUNC_REG3: begin
        if (st.channel_enabled) begin
          st_next.length_count = sqw_pkg::length_load(data[7:3]);
        end
        st_next.period_value   = {data[2:0], st.period_value[7:0]};
        st_next.duty_position  = 3'd0;
        st_next.envelope_start = 1'b1;
      end
      sqw_pkg::FUNC_ENABLE: begin
        st_next.channel_enabled = data[0];
        if (!data[0]) begin
          st_next.length_count = 8'd0;
        end
      end
      sqw_pkg::FUNC_TIMER: begin
        if (timer_dec == 12'd0) begin
          st_next.timer_count   = {1'b0, st.period_value} + 12'd1;
          st_next.duty_position = st.duty_position + 3'd1;
        end else begin
          st_next.timer_count = timer_dec;
        end
      end
      sqw_pkg::FUNC_QUARTER: begin
        if (st.envelope_start) begin
          st_next.envelope_start   = 1'b0;
          st_next.envelope_level   = sqw_pkg::ENV_TOP;
          st_next.envelope_divider = st.volume_value;
        end else if (st.envelope_divider == 4'd0) begin
          st_next.envelope_divider = st.volume_value;
          if (st.envelope_level != 4'd0) begin
            st_next.envelope_level = st.envelope_level - 4'd1;
          end else if (st.halt_loop) begin
            st_next.envelope_level = sqw_pkg::ENV_TOP;
          end
        end else begin
          st_next.envelope_divider = st.envelope_divider - 4'd1;
        end
      end
      sqw_pkg::FUNC_HALF: begin
        if (!st.halt_loop && st.length_count != 8'd0) begin
          st_next.length_count = st.length_count - 8'd1;
        end
        if (st.sweep_divider == 3'd0 && st.sweep_on && st.sweep_amount != 3'd0 &&
            st.period_value >= sqw_pkg::PERIOD_MIN && rng_cur) begin
          st_next.period_value = tgt_cur;
        end
        if (st.sweep_reload || st.sweep_divider == 3'd0) begin
          st_next.sweep_reload  = 1'b0;
          st_next.sweep_divider = st.sweep_divider_period;
        end else begin
          st_next.sweep_divider = st.sweep_divider - 3'd1;
        end
      end
      default: begin
      end
    endcase

    // mute conditions on the updated state
    if (st_next.length_count == 8'd0 || st_next.period_value < sqw_pkg::PERIOD_MIN ||
        !sqw_pkg::duty_bit(st_next.duty_mode, st_next.duty_position) || ovf_new) begin
      level_next = 4'd0;
    end else if (st_next.constant_volume) begin
      level_next = st_next.volume_value;
    end else begin
      level_next = st_next.envelope_level;
    end
    length_active_next = (st_next.length_count != 8'd0);
  end

  // only the mute flag of the new target and the range and target of the current one are needed
  logic unused_new;
  assign unused_new = ovf_cur ^ rng_new ^ (^tgt_new);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= st_reset;
    end else if (step) begin
      st <= st_next;
    end
  end

endmodule

`default_nettype wire

[sv/square_wave_channel.sv]
`default_nettype none

// square-wave sound channel: every event word (register write, enable write,
// timer tick, quarter frame, half frame) yields one result word holding the
// output level after the event and the length-counter status. Events are
// taken one per clock while the output side is not stalled; an event waits
// in the input register, the state update and level logic (timer, envelope,
// length, sweep adder) run on the held word, and the result lands in the
// output register, so an event passes the input and output registers from
// acceptance to result. The block holds input only while a finished result
// is waiting and the output side is stalled. cfg_we/cfg_wdata set the sweep
// negate mode: 1 gives the ones-complement adder of the first channel, 0 the
// twos-complement adder; write it only while no event is in flight.
module square_wave_channel (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  sqw_event_if.sink        events,
  sqw_result_if.source     results
);

  // config register
  logic first_channel;

  // input register
  logic       in_valid;
  logic [2:0] in_func;
  logic [7:0] in_data;

  // output register
  logic       out_valid;
  logic [3:0] out_level;
  logic       out_active;

  logic       advance;
  logic [3:0] level_next;
  logic       active_next;

  // the held word moves on when the output register is free or being drained
  assign advance      = in_valid && (!out_valid || results.ready);
  assign events.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_channel <= 1'b0;
    end else if (cfg_we) begin
      first_channel <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (events.ready) begin
      in_valid <= events.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (events.valid && events.ready) begin
      in_func <= events.func;
      in_data <= events.data;
    end
  end

  sqw_core u_core (
    .clk                (clk),
    .rst                (rst),
    .step               (advance),
    .func               (in_func),
    .data               (in_data),
    .first_channel      (first_channel),
    .level_next         (level_next),
    .length_active_next (active_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_level  <= level_next;
      out_active <= active_next;
    end
  end

  assign results.valid         = out_valid;
  assign results.level         = out_level;
  assign results.length_active = out_active;

endmodule

`default_nettype wire

[sv/sqw_checker.sv]
`default_nettype none

module sqw_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       ev_ready,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [3:0] res_level,
  input wire logic       res_active
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  // a silent length counter always mutes the channel
  a_mute: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_active) |-> (res_level == 4'd0))
    else $error("level nonzero with length counter at zero");

  // input is held back only while a result waits
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !ev_ready |-> res_valid)
    else $error("input stalled with output register empty");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("stalled result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> ($stable(res_level) && $stable(res_active)))
    else $error("stalled result changed");

endmodule

bind square_wave_channel sqw_checker u_sqw_checker (
  .clk        (clk),
  .rst        (rst),
  .ev_ready   (events.ready),
  .res_valid  (results.valid),
  .res_ready  (results.ready),
  .res_level  (results.level),
  .res_active (results.length_active)
);

`default_nettype wire
